// ===== hdl/fat_pkg.sv =====
// ----------------------------------------------------------------------------
// fat_pkg
// Shared types and codes for the flow affinity table: commands, status codes
// and the transaction record that travels down the chain of slot cells.
// ----------------------------------------------------------------------------
package fat_pkg;

	localparam int FAT_CAPACITY = 64;
	localparam int COUNT_W = 7;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
	localparam logic [23:0] TIMEOUT_RESET = 24'd1800;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_ASSIGN = 2'd1;
	localparam logic [1:0] CMD_NODE_DIED = 2'd2;
	localparam logic [1:0] CMD_SWEEP = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_UPDATED = 2'd2;
	localparam logic [1:0] ST_DROPPED = 2'd3;

	// found doubles as the claim flag during the insert pass.
	typedef struct packed {
		logic vld;
		logic [1:0] cmd;
		logic insert;
		logic [31:0] ip;
		logic [47:0] node;
		logic [31:0] now;
		logic found;
		logic free_seen;
		logic hit;
		logic [47:0] found_node;
		logic [COUNT_W-1:0] count;
	} fat_xact_t;

endpackage

// ===== hdl/fat_cell.sv =====
// ----------------------------------------------------------------------------
// fat_cell
// One table slot. Applies the passing transaction to its own entry and hands
// the updated record to the next cell on the following cycle.
// ----------------------------------------------------------------------------
module fat_cell
	import fat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [23:0] idle_timeout,
	input  fat_xact_t x_in,
	output fat_xact_t x_out
);

	logic slot_valid_q;
	logic [31:0] slot_ip_q;
	logic [47:0] slot_node_q;
	logic [31:0] slot_last_q;
	logic vld_q;
	fat_xact_t rec_q;

	logic [31:0] idle;
	logic live;
	logic match;
	fat_xact_t nxt;
	logic valid_nxt;
	logic wr_ip;
	logic wr_node;
	logic wr_last;
	logic kill;

	assign idle = x_in.now - slot_last_q;
	assign live = idle < {8'd0, idle_timeout};
	assign match = slot_valid_q && (slot_ip_q == x_in.ip);

	always_comb begin
		nxt = x_in;
		valid_nxt = slot_valid_q;
		wr_ip = 1'b0;
		wr_node = 1'b0;
		wr_last = 1'b0;
		kill = 1'b0;
		if (x_in.vld) begin
			unique case (x_in.cmd)
				CMD_LOOKUP: begin
					if (match && live) begin
						nxt.hit = 1'b1;
						nxt.found_node = slot_node_q;
						wr_last = 1'b1;
					end
				end
				CMD_ASSIGN: begin
					if (x_in.insert) begin
						if (!slot_valid_q && !x_in.found) begin
							nxt.found = 1'b1;
							valid_nxt = 1'b1;
							wr_ip = 1'b1;
							wr_node = 1'b1;
							wr_last = 1'b1;
						end
					end else begin
						if (match) begin
							nxt.found = 1'b1;
							wr_node = 1'b1;
							wr_last = 1'b1;
						end
						if (!slot_valid_q) begin
							nxt.free_seen = 1'b1;
						end
					end
				end
				CMD_NODE_DIED: kill = slot_valid_q && (slot_node_q == x_in.node);
				CMD_SWEEP: kill = slot_valid_q && !live;
				default: kill = 1'b0;
			endcase
		end
		if (kill) begin
			valid_nxt = 1'b0;
			if (x_in.count != COUNT_MAX) begin
				nxt.count = x_in.count + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
			vld_q <= 1'b0;
		end else begin
			slot_valid_q <= valid_nxt;
			vld_q <= x_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		rec_q <= nxt;
		if (wr_ip) slot_ip_q <= x_in.ip;
		if (wr_node) slot_node_q <= x_in.node;
		if (wr_last) slot_last_q <= x_in.now;
	end

	always_comb begin
		x_out = rec_q;
		x_out.vld = vld_q;
	end

endmodule

// ===== hdl/flow_affinity_table_unit.sv =====
// ----------------------------------------------------------------------------
// flow_affinity_table_unit
// Fully associative flow table built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction walks the whole chain, is held in the pending
// register and then moves to the output register; an assign that inserts a
// new entry walks the chain twice before it reaches the pending register.
// Throughput: one transaction at a time, set by the walk through the chain;
// the next input is taken once the result sits in the output register.
// Reset: arst_n clears all slot valid bits, the control state and restores
// the idle timeout to 1800 at once; slot contents are left as they were.
// ----------------------------------------------------------------------------
module flow_affinity_table_unit
	import fat_pkg::*;
#(
	parameter int CAPACITY = FAT_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] cmd,
	input  logic [31:0] src_ip,
	input  logic [47:0] node_mac,
	input  logic [31:0] now_seconds,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic [47:0] found_node,
	output logic [1:0] status,
	output logic [COUNT_W-1:0] removed_count
);

	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_BUSY = 1'b1;

	logic state_q;
	logic [23:0] timeout_q;
	fat_xact_t link [CAPACITY];
	fat_xact_t inject;
	fat_xact_t last;
	fat_xact_t pend_q;
	logic pend_vld_q;
	logic out_valid_q;
	logic accept;
	logic reinject;
	logic finish;
	logic move;
	logic [1:0] status_nxt;

	// A transaction enters cell 0 and walks one cell per cycle. When it
	// leaves the last cell it either becomes the result or, for an assign
	// that missed and saw a free slot, goes round once more to claim the
	// first free slot.
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q == STATE_BUSY);
	assign last = link[CAPACITY-1];
	assign reinject = last.vld && (last.cmd == CMD_ASSIGN) && !last.insert
		&& !last.found && last.free_seen;
	assign finish = last.vld && !reinject;
	assign move = pend_vld_q && (!out_valid_q || !out_stall);

	always_comb begin
		if (reinject) begin
			inject = last;
			inject.insert = 1'b1;
			inject.found = 1'b0;
		end else begin
			inject = '0;
			inject.vld = accept;
			inject.cmd = cmd;
			inject.ip = src_ip;
			inject.node = node_mac;
			inject.now = now_seconds;
		end
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			if (g == 0) begin : g_head
				fat_cell u_cell (
					.clk(clk), .arst_n(arst_n), .idle_timeout(timeout_q),
					.x_in(inject), .x_out(link[g])
				);
			end else begin : g_body
				fat_cell u_cell (
					.clk(clk), .arst_n(arst_n), .idle_timeout(timeout_q),
					.x_in(link[g-1]), .x_out(link[g])
				);
			end
		end
	endgenerate

	// The status is only meaningful for assign; the insert pass always
	// claims a slot because it is started only when a free one was seen.
	always_comb begin
		if (pend_q.cmd == CMD_ASSIGN) begin
			if (pend_q.insert) status_nxt = ST_INSERTED;
			else if (pend_q.found) status_nxt = ST_UPDATED;
			else status_nxt = ST_DROPPED;
		end else begin
			status_nxt = ST_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
			timeout_q <= TIMEOUT_RESET;
			pend_vld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (accept) state_q <= STATE_BUSY;
			else if (move) state_q <= STATE_IDLE;
			if (finish) pend_vld_q <= 1'b1;
			else if (move) pend_vld_q <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) pend_q <= last;
		if (move) begin
			hit <= pend_q.hit;
			found_node <= pend_q.found_node;
			status <= status_nxt;
			removed_count <= pend_q.count;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_insert_claims: assert property (@(posedge clk) disable iff (!arst_n)
		finish && last.insert |-> last.found)
		else $error("insert pass left the chain without claiming a slot");
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> state_q == STATE_BUSY)
		else $error("pending result while the chain is idle");
	a_enter_chain: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> link[0].vld)
		else $error("accepted transaction did not enter the chain");
`endif

endmodule
